@@ src/hidv_pkg.sv @@
// ----------------------------------------------------------------------------
// hidv_pkg
// Shared types, constants and helper functions for the health identifier
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package hidv_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [3:0] RecordLen  = 4'd10;
  localparam logic [3:0] CountMax   = 4'd15;
  localparam logic [3:0] DateDigits = 4'd6;
  localparam logic [3:0] SumDigits  = 4'd9;

  // Result codes.
  localparam logic [2:0] StatusValid    = 3'd0;
  localparam logic [2:0] StatusMissing  = 3'd1;
  localparam logic [2:0] StatusBlank    = 3'd2;
  localparam logic [2:0] StatusTooFew   = 3'd3;
  localparam logic [2:0] StatusTooMany  = 3'd4;
  localparam logic [2:0] StatusBadChar  = 3'd5;
  localparam logic [2:0] StatusBadDate  = 3'd6;
  localparam logic [2:0] StatusBadCheck = 3'd7;

  // Configuration register indexes.
  localparam logic CfgIdxMod11 = 1'b0;
  localparam logic CfgIdxMod10 = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_MISSING,
    KIND_BLANK
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       last;
    logic       bad;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic mod11_en;
    logic mod10_en;
  } cfg_t;

  // Days in a month, month given as 1 to 12.
  function automatic logic [4:0] month_days(logic [3:0] month);
    logic [4:0] days;
    case (month)
      4'd2:    days = 5'd28;
      4'd4:    days = 5'd30;
      4'd6:    days = 5'd30;
      4'd9:    days = 5'd30;
      4'd11:   days = 5'd30;
      default: days = 5'd31;
    endcase
    return days;
  endfunction

  // Remainder by 11 of a value below 128, by shifted compare and subtract.
  function automatic logic [3:0] mod11(logic [6:0] val);
    logic [6:0] r;
    r = val;
    if (r >= 7'd88) r = r - 7'd88;
    if (r >= 7'd44) r = r - 7'd44;
    if (r >= 7'd22) r = r - 7'd22;
    if (r >= 7'd11) r = r - 7'd11;
    return r[3:0];
  endfunction

  // Two-digit decimal value of a digit pair.
  function automatic logic [6:0] two_digit(logic [3:0] hi, logic [3:0] lo);
    return {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
  endfunction

endpackage

`default_nettype wire

@@ src/hidv_if.sv @@
// ----------------------------------------------------------------------------
// hidv_if
// Valid/ready channel interfaces for character input and status output.
// ----------------------------------------------------------------------------
`default_nettype none

interface hidv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       blank_record;
  logic       missing_record;

  modport source (
    output valid, char_code, last_char, blank_record, missing_record,
    input  ready
  );
  modport sink (
    input  valid, char_code, last_char, blank_record, missing_record,
    output ready
  );
endinterface

interface hidv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;

  modport source (output valid, status, input ready);
  modport sink (input valid, status, output ready);
endinterface

`default_nettype wire

@@ src/hidv_front.sv @@
// ----------------------------------------------------------------------------
// hidv_front
// Accepts input transactions and classifies each one into a compact item.
// ----------------------------------------------------------------------------
`default_nettype none

module hidv_front
  import hidv_pkg::*;
(
  hidv_in_if.sink in_ch,
  input  logic    full_i,
  output logic    push_o,
  output item_t   item_o
);

  logic is_digit;

  assign in_ch.ready = ~full_i;
  assign push_o      = in_ch.valid & ~full_i;

  assign is_digit = (in_ch.char_code >= 8'h30) && (in_ch.char_code <= 8'h39);

  always_comb begin
    item_o.last  = in_ch.last_char;
    item_o.bad   = ~is_digit;
    item_o.digit = is_digit ? in_ch.char_code[3:0] : 4'd0;
    // Missing takes priority over blank.
    if (in_ch.missing_record) begin
      item_o.kind = KIND_MISSING;
    end else if (in_ch.blank_record) begin
      item_o.kind = KIND_BLANK;
    end else begin
      item_o.kind = KIND_CHAR;
    end
  end

endmodule

`default_nettype wire

@@ src/hidv_queue.sv @@
// ----------------------------------------------------------------------------
// hidv_queue
// Small FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module hidv_queue
  import hidv_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output item_t head_item_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] next_ptr(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/hidv_back.sv @@
// ----------------------------------------------------------------------------
// hidv_back
// Consumes classified items, keeps the per-record sums and date digits, and
// registers one status per record on the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hidv_back
  import hidv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        head_valid_i,
  input  item_t       head_item_i,
  output logic        pop_o,
  hidv_out_if.source  out_ch
);

  logic [3:0] count_q, count_d;
  logic       bad_q, bad_d;
  logic [3:0] wsum_q, wsum_d;
  logic [3:0] lsum_q, lsum_d;
  logic [3:0] date_q [6];
  logic       out_valid_q, out_valid_d;
  logic [2:0] status_q, status_d;

  logic       needs_out;
  logic [3:0] count_inc;
  logic       bad_all;
  logic [3:0] weight;
  logic [6:0] wprod;
  logic [6:0] wsum_raw;
  logic [4:0] dbl;
  logic [4:0] lterm;
  logic [4:0] lsum_raw;
  logic [6:0] day;
  logic [6:0] month;
  logic [1:0] yy_mod4;
  logic [4:0] day_lim;
  logic       date_ok;
  logic [3:0] c11;
  logic [3:0] c10;
  logic       check_ok;
  logic [2:0] final_status;

  assign needs_out = (head_item_i.kind != KIND_CHAR) || head_item_i.last;
  assign pop_o     = head_valid_i && (!needs_out || !out_valid_q || out_ch.ready);

  assign count_inc = (count_q == CountMax) ? CountMax : count_q + 1'b1;
  assign bad_all   = bad_q | head_item_i.bad;

  // Mod-11 weights run from 10 down to 2 over the first nine digits.
  assign weight   = RecordLen - count_q;
  assign wprod    = 7'(head_item_i.digit * weight);
  assign wsum_raw = {3'b000, wsum_q} + wprod;

  // Luhn doubles digits at even positions.
  assign dbl      = {head_item_i.digit, 1'b0};
  assign lterm    = count_q[0] ? {1'b0, head_item_i.digit}
                  : ((dbl > 5'd9) ? dbl - 5'd9 : dbl);
  assign lsum_raw = {1'b0, lsum_q} + lterm;

  // Date check over the stored DDMMYY digits.
  assign day     = two_digit(date_q[0], date_q[1]);
  assign month   = two_digit(date_q[2], date_q[3]);
  assign yy_mod4 = date_q[5][1:0] + {date_q[4][0], 1'b0};

  always_comb begin
    day_lim = month_days(month[3:0]);
    if (month == 7'd2 && yy_mod4 == 2'd0) begin
      day_lim = 5'd29;
    end
    date_ok = (month >= 7'd1) && (month <= 7'd12) &&
              (day >= 7'd1) && (day <= {2'b00, day_lim});
  end

  assign c11 = (wsum_q == 4'd0) ? 4'd0 : 4'd11 - wsum_q;
  assign c10 = (lsum_q == 4'd0) ? 4'd0 : 4'd10 - lsum_q;
  assign check_ok = (cfg_i.mod11_en && c11 == head_item_i.digit) ||
                    (cfg_i.mod10_en && c10 == head_item_i.digit);

  always_comb begin
    case (head_item_i.kind)
      KIND_MISSING: final_status = StatusMissing;
      KIND_BLANK:   final_status = StatusBlank;
      default: begin
        if (count_inc < RecordLen) begin
          final_status = StatusTooFew;
        end else if (count_inc > RecordLen) begin
          final_status = StatusTooMany;
        end else if (bad_all) begin
          final_status = StatusBadChar;
        end else if (!date_ok) begin
          final_status = StatusBadDate;
        end else if (check_ok) begin
          final_status = StatusValid;
        end else begin
          final_status = StatusBadCheck;
        end
      end
    endcase
  end

  always_comb begin
    count_d     = count_q;
    bad_d       = bad_q;
    wsum_d      = wsum_q;
    lsum_d      = lsum_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (needs_out) begin
        // Record ends here: report and start a fresh record.
        out_valid_d = 1'b1;
        status_d    = final_status;
        count_d     = '0;
        bad_d       = 1'b0;
        wsum_d      = '0;
        lsum_d      = '0;
      end else begin
        count_d = count_inc;
        bad_d   = bad_all;
        if (count_q < SumDigits) begin
          wsum_d = mod11(wsum_raw);
          lsum_d = (lsum_raw >= 5'd10) ? 4'(lsum_raw - 5'd10) : lsum_raw[3:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      bad_q       <= 1'b0;
      wsum_q      <= '0;
      lsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      bad_q       <= bad_d;
      wsum_q      <= wsum_d;
      lsum_q      <= lsum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    if (pop_o && head_item_i.kind == KIND_CHAR && count_q < DateDigits) begin
      date_q[count_q[2:0]] <= head_item_i.digit;
    end
  end

  assign out_ch.valid  = out_valid_q;
  assign out_ch.status = status_q;

endmodule

`default_nettype wire

@@ src/health_id_validator.sv @@
// ----------------------------------------------------------------------------
// health_id_validator
// Checks ten-digit health identifiers (DDMMYY date, check digit) that arrive
// one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character per transaction; last_char closes a record.
//   A transaction flagged missing_record or blank_record is a whole record on
//   its own and its other fields are ignored.
//   out_ch carries one status per record: 0 valid, 1 missing, 2 blank,
//   3 too few, 4 too many, 5 bad character, 6 bad date, 7 bad checksum.
//   The cfg_* port writes the two checksum enables; write only while idle.
// Timing:
//   One character per cycle sustained while out_ch accepts. A record's status
//   passes through its queue entry and then the status register on out_ch.
//   A queue of QUEUE_DEPTH items sits between the input decode and the
//   accumulating back end, which retires one item per cycle unless stalled.
// Reset:
//   Both checksum enables come up set, the queue is empty and no status is
//   pending. When out_ch stalls, the status register holds, the queue fills
//   and in_ch.ready drops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module health_id_validator
  import hidv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hidv_in_if.sink     in_ch,
  hidv_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  push;
  item_t push_item;
  logic  full;
  logic  pop;
  logic  head_valid;
  item_t head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mod11_en <= 1'b1;
      cfg_q.mod10_en <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIdxMod11: cfg_q.mod11_en <= cfg_wdata_i;
        CfgIdxMod10: cfg_q.mod10_en <= cfg_wdata_i;
        default:     cfg_q          <= cfg_q;
      endcase
    end
  end

  hidv_front u_front (
    .in_ch  (in_ch),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  hidv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  hidv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

@@ src/hidv_checker.sv @@
// ----------------------------------------------------------------------------
// hidv_checker
// Port-level checks of the validator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hidv_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_status_i
);

  // No status is pending while reset is applied.
  a_idle_in_reset : assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("status offered during reset");

  // The input only backs up when a status is waiting on the output.
  a_backpressure_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no pending status");

  // A stalled status stays offered and unchanged.
  a_status_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("stalled status changed or dropped");

  // The input is ready again right after reset.
  a_ready_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_i)
    else $error("input not ready after reset");

  // A waiting input transaction is not withdrawn before it is taken.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i)
    else $error("input transaction withdrawn while waiting");

endmodule

bind health_id_validator hidv_checker u_hidv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_ch.valid),
  .in_ready_i   (in_ch.ready),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .out_status_i (out_ch.status)
);

`default_nettype wire

@@ verif/tb_health_id_validator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_health_id_validator
// Self-checking bench for the health identifier validator. Records of random
// and edge-case identifiers stream in one character per transaction. A local
// scoreboard tracks length, bad characters, date digits and both checksums,
// and compares every status against the block across several enable settings.
// ----------------------------------------------------------------------------

module tb_health_id_validator;
  import hidv_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int HoldCycles  = 150;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       blank;
    logic       missing;
  } char_item_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_COMB
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic cfg_wdata_i;

  hidv_in_if  char_ch ();
  hidv_out_if stat_ch ();

  health_id_validator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (char_ch),
    .out_ch      (stat_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Scoreboard copy of the enables and of the record in progress.
  logic       en_mod11;
  logic       en_mod10;
  logic [3:0] id_len;
  logic       id_bad;
  logic [3:0] dob_dig [6];
  logic [3:0] wsum;
  logic [3:0] lsum;

  char_item_t char_backlog [$];
  logic [2:0] status_expected [$];

  int       chars_queued     = 0;
  int       chars_taken      = 0;
  int       statuses_checked = 0;
  int       errors           = 0;
  int       quiet            = 0;
  int       status_seen [8]  = '{default: 0};
  int       hold_asked       = 0;
  int       hold_done        = 0;
  int       hold_left        = 0;
  int       mode_left        = 0;
  int       rx_phase         = 0;
  int       burst_left       = 0;
  int       gap_left         = 0;
  rx_mode_e rx_mode          = RX_OPEN;
  logic     in_hs            = 1'b0;

  function automatic int month_length(int month, int yy);
    case (month)
      2:           return (yy % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic void clear_id();
    id_len = '0;
    id_bad = 1'b0;
    wsum   = '0;
    lsum   = '0;
    foreach (dob_dig[k]) dob_dig[k] = '0;
  endfunction

  function automatic logic [2:0] id_status(int tenth);
    int day;
    int month;
    int yy;
    int c11;
    int c10;
    day   = dob_dig[0] * 10 + dob_dig[1];
    month = dob_dig[2] * 10 + dob_dig[3];
    yy    = dob_dig[4] * 10 + dob_dig[5];
    if (id_len < RecordLen) return StatusTooFew;
    if (id_len > RecordLen) return StatusTooMany;
    if (id_bad) return StatusBadChar;
    if (month < 1 || month > 12 || day < 1 || day > month_length(month, yy))
      return StatusBadDate;
    c11 = (11 - wsum) % 11;
    c10 = (10 - lsum) % 10;
    if (en_mod11 && c11 == tenth) return StatusValid;
    if (en_mod10 && c10 == tenth) return StatusValid;
    return StatusBadCheck;
  endfunction

  // Folds one accepted character into the record and queues the status that
  // a record end produces.
  function automatic void absorb_char(char_item_t it);
    int pos;
    int dig;
    int lv;
    if (it.missing || it.blank) begin
      status_expected.push_back(it.missing ? StatusMissing : StatusBlank);
      clear_id();
      return;
    end
    pos = int'(id_len);
    dig = 0;
    if (it.code >= 8'h30 && it.code <= 8'h39) dig = int'(it.code) - 48;
    else id_bad = 1'b1;
    if (pos < 6) dob_dig[pos] = dig[3:0];
    if (pos < 9) begin
      wsum = 4'((wsum + dig * (10 - pos)) % 11);
      lv = dig;
      if (pos % 2 == 0) begin
        lv = 2 * dig;
        if (lv > 9) lv = lv - 9;
      end
      lsum = 4'((lsum + lv) % 10);
    end
    if (id_len != CountMax) id_len = id_len + 1'b1;
    if (it.last) begin
      status_expected.push_back(id_status(dig));
      clear_id();
    end
  endfunction

  function automatic void queue_text(logic [7:0] txt [$], logic close);
    char_item_t it;
    foreach (txt[k]) begin
      it.code    = txt[k];
      it.last    = close && (k == txt.size() - 1);
      it.blank   = 1'b0;
      it.missing = 1'b0;
      char_backlog.push_back(it);
      chars_queued++;
    end
  endfunction

  function automatic void queue_flag(logic [7:0] code, logic last, logic missing,
                                     logic blank);
    char_item_t it;
    it.code    = code;
    it.last    = last;
    it.missing = missing;
    it.blank   = blank;
    char_backlog.push_back(it);
    chars_queued++;
  endfunction

  function automatic logic [7:0] nondigit();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = 8'h2F;
      1: b = 8'h3A;
      2: b = 8'h00;
      3: b = 8'hFF;
      default: begin
        b = 8'($urandom_range(0, 255));
        if (b >= 8'h30 && b <= 8'h39) b = 8'h41;
      end
    endcase
    return b;
  endfunction

  // Builds a ten-digit identifier. The tail selects the check digit: the
  // weighted one (falling back to Luhn when it would be 10), Luhn, or random.
  function automatic void queue_id(int day, int month, int yy, int tail, int bad_pos);
    int         d [10];
    logic [7:0] txt [$];
    int         s11;
    int         s10;
    int         lv;
    int         c11;
    int         k;
    d[0] = day / 10;
    d[1] = day % 10;
    d[2] = month / 10;
    d[3] = month % 10;
    d[4] = yy / 10;
    d[5] = yy % 10;
    for (k = 6; k < 9; k++) d[k] = $urandom_range(0, 9);
    s11 = 0;
    s10 = 0;
    for (k = 0; k < 9; k++) begin
      s11 = s11 + d[k] * (10 - k);
      lv  = (k % 2 == 0) ? 2 * d[k] : d[k];
      s10 = s10 + ((lv > 9) ? lv - 9 : lv);
    end
    c11 = (11 - s11 % 11) % 11;
    case (tail)
      0:       d[9] = (c11 == 10) ? (10 - s10 % 10) % 10 : c11;
      1:       d[9] = (10 - s10 % 10) % 10;
      default: d[9] = $urandom_range(0, 9);
    endcase
    for (k = 0; k < 10; k++) txt.push_back(8'(8'h30 + d[k]));
    if (bad_pos >= 0) txt[bad_pos] = nondigit();
    queue_text(txt, 1'b1);
  endfunction

  function automatic void pick_date(output int day, output int month, output int yy);
    yy    = $urandom_range(0, 99);
    month = $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) day = month_length(month, yy);
    else day = $urandom_range(1, month_length(month, yy));
  endfunction

  function automatic void queue_random_record();
    int         pick;
    int         day;
    int         month;
    int         yy;
    int         n;
    int         f;
    logic [7:0] txt [$];
    pick = $urandom_range(0, 99);
    pick_date(day, month, yy);
    if (pick < 40) begin
      queue_id(day, month, yy, $urandom_range(0, 2), -1);
    end else if (pick < 50) begin
      case ($urandom_range(0, 4))
        0: month = 0;
        1: month = $urandom_range(13, 99);
        2: day = 0;
        3: day = $urandom_range(month_length(month, yy) + 1, 99);
        default: begin
          month = 2;
          day   = 29;
          yy    = 4 * $urandom_range(0, 24) + $urandom_range(1, 3);
        end
      endcase
      queue_id(day, month, yy, $urandom_range(0, 1), -1);
    end else if (pick < 60) begin
      n = $urandom_range(0, 1) ? $urandom_range(1, 9) : $urandom_range(11, 20);
      repeat (n) txt.push_back(8'(8'h30 + $urandom_range(0, 9)));
      queue_text(txt, 1'b1);
    end else if (pick < 70) begin
      queue_id(day, month, yy, $urandom_range(0, 1), $urandom_range(0, 9));
    end else if (pick < 84) begin
      // A record cut short by a missing or blank flag, or a flag on its own.
      if (pick >= 77) begin
        repeat ($urandom_range(1, 12)) txt.push_back(8'(8'h30 + $urandom_range(0, 9)));
        queue_text(txt, 1'b0);
      end
      f = $urandom_range(1, 3);
      queue_flag(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), f[0], f[1]);
    end else begin
      repeat ($urandom_range(1, 18)) txt.push_back(8'($urandom_range(0, 255)));
      queue_text(txt, 1'b1);
    end
  endfunction

  task automatic settle();
    while (chars_taken != chars_queued || status_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxMod11) en_mod11 = val;
    else en_mod10 = val;
  endtask

  task automatic run_phase(input logic m11, input logic m10, input int n_items,
                           input bit hold);
    int goal;
    settle();
    write_reg(CfgIdxMod11, m11);
    write_reg(CfgIdxMod10, m10);
    if (hold) hold_asked++;
    goal = chars_queued + n_items;
    while (chars_queued < goal) queue_random_record();
  endtask

  // Character driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    char_item_t nxt;
    if (rst_ni && (!char_ch.valid || in_hs)) begin
      if (gap_left > 0) begin
        gap_left--;
        char_ch.valid <= 1'b0;
      end else if (char_backlog.size() != 0) begin
        nxt = char_backlog.pop_front();
        char_ch.valid          <= 1'b1;
        char_ch.char_code      <= nxt.code;
        char_ch.last_char      <= nxt.last;
        char_ch.blank_record   <= nxt.blank;
        char_ch.missing_record <= nxt.missing;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        char_ch.valid <= 1'b0;
      end
    end
  end

  // Status receiver: switches among stall patterns, and on request holds off
  // long enough for the block to back up into its input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_asked != hold_done) begin
        hold_done++;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(64, 256);
      end else begin
        mode_left--;
      end
      rx_phase++;
      if (hold_left > 0) begin
        hold_left--;
        stat_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   stat_ch.ready <= 1'b1;
          RX_COIN:   stat_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: stat_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   stat_ch.ready <= (rx_phase % 8) > 2;
        endcase
      end
    end
  end

  // Monitor, scoreboard and watchdog.
  always @(posedge clk_i) begin
    char_item_t got;
    logic [2:0] want;
    if (rst_ni) begin
      in_hs <= char_ch.valid && char_ch.ready;
      if (stat_ch.valid && stat_ch.ready) begin
        status_seen[stat_ch.status]++;
        if (status_expected.size() == 0) begin
          errors++;
          $display("%0t: status %0d arrived with none expected", $time, stat_ch.status);
        end else begin
          want = status_expected.pop_front();
          statuses_checked++;
          if (want !== stat_ch.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want, stat_ch.status);
          end
        end
      end
      if (char_ch.valid && char_ch.ready) begin
        got.code    = char_ch.char_code;
        got.last    = char_ch.last_char;
        got.blank   = char_ch.blank_record;
        got.missing = char_ch.missing_record;
        absorb_char(got);
        chars_taken++;
      end
      if ((char_ch.valid && char_ch.ready) || (stat_ch.valid && stat_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] txt [$];
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CfgIdxMod11;
    cfg_wdata_i            = 1'b0;
    char_ch.valid          = 1'b0;
    char_ch.char_code      = 8'h00;
    char_ch.last_char      = 1'b0;
    char_ch.blank_record   = 1'b0;
    char_ch.missing_record = 1'b0;
    stat_ch.ready          = 1'b0;
    en_mod11               = 1'b1;
    en_mod10               = 1'b1;
    clear_id();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Flags win over whatever else the transaction carries; missing beats blank.
    queue_flag(8'hFF, 1'b1, 1'b1, 1'b0);
    queue_flag(8'h00, 1'b0, 1'b0, 1'b1);
    queue_flag(8'hA5, 1'b1, 1'b1, 1'b1);
    txt = {8'h37};
    queue_text(txt, 1'b1);
    queue_id(31, 12, 99, 0, -1);
    queue_id(29, 2, 4, 1, 7);

    run_phase(1'b1, 1'b1, 280, 1'b1);
    run_phase(1'b0, 1'b0, 200, 1'b0);
    run_phase(1'b1, 1'b0, 300, 1'b0);
    run_phase(1'b0, 1'b1, 300, 1'b0);
    run_phase(1'b1, 1'b1, 300, 1'b1);
    settle();

    $display("Checked %0d statuses from %0d input transactions over five enable settings.",
             statuses_checked, chars_taken);
    $display("Statuses seen: valid %0d, missing %0d, blank %0d, too few %0d, too many %0d,",
             status_seen[StatusValid], status_seen[StatusMissing],
             status_seen[StatusBlank], status_seen[StatusTooFew], status_seen[StatusTooMany]);
    $display("  bad char %0d, bad date %0d, bad checksum %0d",
             status_seen[StatusBadChar], status_seen[StatusBadDate],
             status_seen[StatusBadCheck]);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/hidv_pkg.sv
src/hidv_if.sv
src/hidv_front.sv
src/hidv_queue.sv
src/hidv_back.sv
src/health_id_validator.sv
src/hidv_checker.sv
verif/tb_health_id_validator.sv
